// ----- rtl/llmc_pkg.sv -----
// Package for the limit line margin checker: field widths, reset values,
// operation/status/register codes, segment entry type and state enums.
// No dependencies.
package llmc_pkg;

  localparam int FREQ_W   = 33;
  localparam int LVL_W    = 17;
  localparam int MARGIN_W = 18;
  localparam int EXP_W    = 6;
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int MAG_W    = 17;
  localparam int PROD_W   = MAG_W + LOG_W + 1;

  localparam logic signed [MARGIN_W-1:0] MARGIN_MAX  = 18'sd102400;
  localparam logic signed [MARGIN_W-1:0] MARGIN_MIN  = -18'sd102400;
  localparam logic signed [MARGIN_W-1:0] WORST_RESET = 18'sd102400;
  localparam logic signed [LVL_W-1:0]    PEAK_RESET  = -17'sd51200;
  localparam logic signed [LVL_W-1:0]    EMPTY_RESET = -17'sd51200;
  localparam logic [15:0]                THRESH_RESET = 16'd1536;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_POINT   = 1'b1;

  localparam logic [1:0] STATUS_PASS     = 2'd0;
  localparam logic [1:0] STATUS_MARGINAL = 2'd1;
  localparam logic [1:0] STATUS_FAIL     = 2'd2;

  localparam logic [1:0] REG_SEGMENTS  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_EMPTY     = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0]       start_freq;
    logic [FREQ_W-1:0]       stop_freq;
    logic signed [LVL_W-1:0] start_level;
    logic signed [LVL_W-1:0] stop_level;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_LOG_START,
    ST_LOG_STOP,
    ST_LOG_POINT,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } llmc_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQUARE
  } log_state_t;

endpackage

// ----- rtl/llmc_log2.sv -----
// Fixed-point log2 of a 33-bit frequency: 6-bit exponent, 16-bit fraction.
// Normalizes by shifts of four bits or one bit, then one squaring step a cycle.
// Depends on llmc_pkg.
module llmc_log2 import llmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FREQ_W-1:0] value,
  output logic              done,
  output logic [LOG_W-1:0]  result
);

  log_state_t        state, state_next;
  logic [FREQ_W-1:0] val;
  logic [EXP_W-1:0]  expo;
  logic [31:0]       mant;
  logic [3:0]        cnt;
  logic [FRAC_W-1:0] frac, frac_next;
  logic [63:0]       prod;
  logic [32:0]       sq;
  logic              finish;

  assign prod = {32'b0, mant} * {32'b0, mant};
  assign sq   = prod[63:31];
  assign frac_next = frac | (sq[32] ? (16'd1 << cnt) : 16'd0);

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: begin
        if (start && value != '0) state_next = L_NORM;
      end
      L_NORM: begin
        if (val[FREQ_W-1]) state_next = L_SQUARE;
      end
      L_SQUARE: begin
        if (cnt == 4'd0) state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      L_IDLE:   finish = start && value == '0;
      L_SQUARE: finish = cnt == 4'd0;
      default:  finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          val  <= value;
          expo <= 6'd32;
          frac <= '0;
        end
      end
      L_NORM: begin
        // take the mantissa as Q31 once the leading one reaches the top
        if (val[FREQ_W-1]) begin
          mant <= val[FREQ_W-1:1];
          cnt  <= 4'd15;
        end else if (val[FREQ_W-1:FREQ_W-4] == 4'd0) begin
          val  <= val << 4;
          expo <= expo - 6'd4;
        end else begin
          val  <= val << 1;
          expo <= expo - 6'd1;
        end
      end
      L_SQUARE: begin
        mant <= sq[32] ? sq[32:1] : sq[31:0];
        frac <= frac_next;
        cnt  <= cnt - 4'd1;
      end
      default: ;
    endcase
    if (finish) result <= (state == L_IDLE) ? '0 : {expo, frac_next};
  end

endmodule

// ----- rtl/llmc_div.sv -----
// Restoring divider for the interpolation step: one quotient bit a cycle.
// Quotient is known to fit 17 bits, so only 17 steps run. Depends on llmc_pkg.
module llmc_div import llmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [LOG_W-1:0]  divisor,
  output logic              done,
  output logic [MAG_W-1:0]  quotient
);

  logic             busy;
  logic [4:0]       cnt;
  logic [LOG_W-1:0] rem;
  logic [MAG_W-1:0] low;
  logic [LOG_W:0]   trial;
  logic             ge;

  assign trial = {rem, low[MAG_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 5'd0;
      if (start)                     busy <= 1'b1;
      else if (busy && cnt == 5'd0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // the upper part is already below the divisor
      rem <= dividend[PROD_W-2:MAG_W];
      low <= dividend[MAG_W-1:0];
      cnt <= 5'(MAG_W - 1);
    end else if (busy) begin
      rem      <= ge ? LOG_W'(trial - {1'b0, divisor}) : trial[LOG_W-1:0];
      low      <= low << 1;
      quotient <= {quotient[MAG_W-2:0], ge};
      cnt      <= cnt - 5'd1;
    end
  end

endmodule

// ----- rtl/limit_line_margin_checker_unit.sv -----
// Limit line margin checker: segment table memory, search sequencer,
// log interpolation, margin classification and per-scan statistics.
// Depends on llmc_pkg, llmc_log2, llmc_div.
//
//  channel | signals                          | accepted when
//  --------+----------------------------------+---------------------------
//  input   | in_valid/in_ready + fields       | in_valid & in_ready
//  output  | out_valid/out_ready + fields     | out_valid & out_ready
//  config  | APB psel/penable/pwrite/paddr    | psel & penable & pwrite
//
// A segment write is stored in the table as it is accepted. A point passes its accept
// step, a read and a check step per segment searched (one memory read each) and a step
// that loads the result. An interpolated hit adds three log2 runs, a setup step and a
// division; most of that time goes to the log2 unit's squaring loop.
// Reset clears control state and the statistics; table entries are undefined
// until written. A result waits in the output register; a new word is taken
// meanwhile, and the sequencer holds in its last step if the register is full.
module limit_line_margin_checker_unit import llmc_pkg::*; #(
  parameter int MAX_SEGMENTS = 8,
  parameter int COUNT_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [2:0]                 segment_index,
  input  logic [FREQ_W-1:0]          freq_hz,
  input  logic [FREQ_W-1:0]          stop_frequency_hz,
  input  logic signed [LVL_W-1:0]    level,
  input  logic signed [LVL_W-1:0]    stop_level,
  input  logic                       scan_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [LVL_W-1:0]    limit_level,
  output logic signed [MARGIN_W-1:0] margin,
  output logic [1:0]                 status,
  output logic signed [MARGIN_W-1:0] worst_margin,
  output logic [COUNT_BITS-1:0]      marginal_count,
  output logic [COUNT_BITS-1:0]      failing_count,
  output logic signed [LVL_W-1:0]    peak_emission,
  output logic [FREQ_W-1:0]          peak_frequency_hz
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [5:0] MAX_SEG6 = 6'(MAX_SEGMENTS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [3:0]              seg_cnt;
  logic [15:0]             thresh;
  logic signed [LVL_W-1:0] empty_lim;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cnt   <= 4'd0;
      thresh    <= THRESH_RESET;
      empty_lim <= EMPTY_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SEGMENTS:  seg_cnt   <= pwdata[3:0];
        REG_THRESHOLD: thresh    <= pwdata[15:0];
        REG_EMPTY:     empty_lim <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEGMENTS:  prdata = {28'b0, seg_cnt};
      REG_THRESHOLD: prdata = {16'b0, thresh};
      REG_EMPTY:     prdata = {{(32-LVL_W){empty_lim[LVL_W-1]}}, empty_lim};
      default:       prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  llmc_state_t             state, state_next;
  logic [IW-1:0]           seg_i;
  logic [FREQ_W-1:0]       pt_freq;
  logic signed [LVL_W-1:0] pt_level;
  logic [FREQ_W-1:0]       hit_f2, first_f1;
  logic signed [LVL_W-1:0] hit_s1, hit_s2, first_s1, lim;
  logic [LOG_W-1:0]        l1, l2, den, num;
  logic                    diff_neg;
  logic [MAG_W-1:0]        mag;

  // segment table
  seg_t          seg_mem [MAX_SEGMENTS];
  seg_t          seg_rd, wr_data;
  logic          wr_en, rd_en, accept;
  logic [5:0]    idx_ext, n_use, cnt6, seg_i6;
  logic [IW-1:0] wr_addr;

  assign accept  = in_valid && in_ready;
  assign idx_ext = {3'b0, segment_index};
  assign wr_addr = idx_ext[IW-1:0];
  assign wr_en   = accept && operation == OP_SEGMENT && idx_ext < MAX_SEG6;
  assign wr_data = '{start_freq: freq_hz, stop_freq: stop_frequency_hz,
                     start_level: level, stop_level: stop_level};

  always_ff @(posedge clk) begin
    if (wr_en) seg_mem[wr_addr] <= wr_data;
    if (rd_en) seg_rd <= seg_mem[seg_i];
  end

  assign cnt6   = {2'b0, seg_cnt};
  assign n_use  = (cnt6 > MAX_SEG6) ? MAX_SEG6 : cnt6;
  assign seg_i6 = 6'(seg_i);

  // search and interpolation terms
  logic                    in_range, zero_bound, seg_last;
  logic [FREQ_W-1:0]       first_f1_c;
  logic signed [LVL_W-1:0] first_s1_c;
  logic signed [LVL_W:0]   half_sum, diff_c, interp;
  logic [LOG_W-1:0]        lf, den_c, num_raw;
  logic                    log_start, log_done, div_start, div_done, out_load;
  logic [FREQ_W-1:0]       log_value;
  logic [LOG_W-1:0]        log_result;
  logic [PROD_W-1:0]       dividend;
  logic [MAG_W-1:0]        quotient;

  assign in_range   = pt_freq >= seg_rd.start_freq && pt_freq <= seg_rd.stop_freq;
  assign zero_bound = seg_rd.start_freq == '0 || seg_rd.stop_freq == '0;
  assign seg_last   = seg_i6 == n_use - 6'd1;
  assign first_f1_c = (seg_i == '0) ? seg_rd.start_freq : first_f1;
  assign first_s1_c = (seg_i == '0) ? seg_rd.start_level : first_s1;
  assign half_sum   = (LVL_W+1)'(seg_rd.start_level) + (LVL_W+1)'(seg_rd.stop_level);
  assign lf         = log_result;
  assign den_c      = l2 - l1;
  assign num_raw    = (lf > l1) ? lf - l1 : '0;
  assign diff_c     = (LVL_W+1)'(hit_s2) - (LVL_W+1)'(hit_s1);
  assign dividend   = PROD_W'({23'b0, mag} * {18'b0, num}) + PROD_W'(den >> 1);
  assign interp     = diff_neg ? (LVL_W+1)'(hit_s1) - (LVL_W+1)'(quotient)
                               : (LVL_W+1)'(hit_s1) + (LVL_W+1)'(quotient);

  llmc_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .value  (log_value),
    .done   (log_done),
    .result (log_result)
  );

  llmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_POINT)
          state_next = (n_use == 6'd0) ? ST_FINISH : ST_READ;
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (in_range)      state_next = zero_bound ? ST_FINISH : ST_LOG_START;
        else if (seg_last) state_next = ST_FINISH;
        else               state_next = ST_READ;
      end
      ST_LOG_START: begin
        if (log_done) state_next = ST_LOG_STOP;
      end
      ST_LOG_STOP: begin
        if (log_done) state_next = ST_LOG_POINT;
      end
      ST_LOG_POINT: begin
        if (log_done) state_next = (l2 <= l1) ? ST_FINISH : ST_SCALE;
      end
      ST_SCALE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    log_start = 1'b0;
    log_value = pt_freq;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_CHECK: begin
        log_start = in_range && !zero_bound;
        log_value = seg_rd.start_freq;
      end
      ST_LOG_START: begin
        log_start = log_done;
        log_value = hit_f2;
      end
      ST_LOG_STOP: begin
        log_start = log_done;
        log_value = pt_freq;
      end
      ST_SCALE:  div_start = 1'b1;
      ST_FINISH: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pt_freq  <= freq_hz;
        pt_level <= level;
        seg_i    <= '0;
        lim      <= empty_lim;
      end
      ST_CHECK: begin
        first_f1 <= first_f1_c;
        first_s1 <= first_s1_c;
        hit_f2   <= seg_rd.stop_freq;
        hit_s1   <= seg_rd.start_level;
        hit_s2   <= seg_rd.stop_level;
        if (in_range)
          lim <= zero_bound ? half_sum[LVL_W:1] : seg_rd.start_level;
        else if (seg_last)
          lim <= (pt_freq < first_f1_c) ? first_s1_c : seg_rd.stop_level;
        else
          seg_i <= seg_i + 1'b1;
      end
      ST_LOG_START: begin
        if (log_done) l1 <= log_result;
      end
      ST_LOG_STOP: begin
        if (log_done) l2 <= log_result;
      end
      ST_LOG_POINT: begin
        den      <= den_c;
        num      <= (num_raw > den_c) ? den_c : num_raw;
        diff_neg <= diff_c[LVL_W];
        mag      <= diff_c[LVL_W] ? MAG_W'(-diff_c) : diff_c[MAG_W-1:0];
      end
      ST_DIVIDE: begin
        if (div_done) lim <= interp[LVL_W-1:0];
      end
      default: ;
    endcase
  end

  // margin, classification and statistics
  logic signed [MARGIN_W-1:0] mfull, msat;
  logic [1:0]                 status_c;

  assign mfull = MARGIN_W'(lim) - MARGIN_W'(pt_level);
  assign msat  = (mfull > MARGIN_MAX) ? MARGIN_MAX :
                 (mfull < MARGIN_MIN) ? MARGIN_MIN : mfull;

  always_comb begin
    if (msat >= $signed({2'b0, thresh})) status_c = STATUS_PASS;
    else if (msat >= 0)                  status_c = STATUS_MARGINAL;
    else                                 status_c = STATUS_FAIL;
  end

  logic signed [MARGIN_W-1:0] worst;
  logic [COUNT_BITS-1:0]      marg_tally, fail_tally;
  logic signed [LVL_W-1:0]    peak;
  logic [FREQ_W-1:0]          peak_freq;

  always_ff @(posedge clk) begin
    if (rst || (accept && operation == OP_POINT && scan_start)) begin
      worst      <= WORST_RESET;
      marg_tally <= '0;
      fail_tally <= '0;
      peak       <= PEAK_RESET;
      peak_freq  <= '0;
    end else if (out_load) begin
      if (status_c == STATUS_MARGINAL && marg_tally != COUNT_MAX)
        marg_tally <= marg_tally + 1'b1;
      if (status_c == STATUS_FAIL && fail_tally != COUNT_MAX)
        fail_tally <= fail_tally + 1'b1;
      if (msat < worst) worst <= msat;
      if (pt_level > peak) begin
        peak      <= pt_level;
        peak_freq <= pt_freq;
      end
    end
  end

  // output word: fold in this point's update as it is loaded
  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      limit_level  <= lim;
      margin       <= msat;
      status       <= status_c;
      worst_margin <= (msat < worst) ? msat : worst;
      marginal_count <= (status_c == STATUS_MARGINAL && marg_tally != COUNT_MAX)
                        ? marg_tally + 1'b1 : marg_tally;
      failing_count  <= (status_c == STATUS_FAIL && fail_tally != COUNT_MAX)
                        ? fail_tally + 1'b1 : fail_tally;
      peak_emission     <= (pt_level > peak) ? pt_level : peak;
      peak_frequency_hz <= (pt_level > peak) ? pt_freq : peak_freq;
    end
  end

endmodule
